[src/small_matrix_inverse_assert.svh]
// Assertion macros for the matrix inverse block.
`ifndef SMALL_MATRIX_INVERSE_ASSERT_SVH
`define SMALL_MATRIX_INVERSE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/smi_pkg.sv]
package smi_pkg;

    localparam int ELEM_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int NUM_ELEMS   = 9;
    localparam int PROD_WIDTH  = 2 * ELEM_WIDTH;
    localparam int MINOR_WIDTH = 2 * ELEM_WIDTH + 1;
    localparam int DET_WIDTH   = 3 * ELEM_WIDTH + 3;
    localparam int REM_WIDTH   = DET_WIDTH + ELEM_WIDTH + 1;
    localparam int QUO_WIDTH   = ELEM_WIDTH + 1;
    localparam int STAGES      = ELEM_WIDTH + 8;

    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_1    = 2'd1;
    localparam logic [1:0] SIZE_2    = 2'd2;
    localparam logic [1:0] SIZE_3    = 2'd3;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_SINGULAR = 1'b1;

    typedef logic signed [ELEM_WIDTH-1:0]  elem_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [MINOR_WIDTH-1:0] minor_t;
    typedef logic signed [DET_WIDTH-1:0]   det_t;

    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

    // Cofactor k = e[P]*e[Q] - e[S]*e[T], elements row-major from 0
    localparam int MINOR_P [NUM_ELEMS] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int MINOR_Q [NUM_ELEMS] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int MINOR_S [NUM_ELEMS] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int MINOR_T [NUM_ELEMS] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    typedef struct packed {
        logic [1:0] matrix_size;
        elem_t      m11;
        elem_t      m12;
        elem_t      m13;
        elem_t      m21;
        elem_t      m22;
        elem_t      m23;
        elem_t      m31;
        elem_t      m32;
        elem_t      m33;
    } item_t;

    typedef struct packed {
        logic  status;
        elem_t determinant;
        elem_t inv11;
        elem_t inv12;
        elem_t inv13;
        elem_t inv21;
        elem_t inv22;
        elem_t inv23;
        elem_t inv31;
        elem_t inv32;
        elem_t inv33;
    } result_t;

    function automatic prod_t mul_elems(elem_t a, elem_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    function automatic minor_t mul_low(elem_t e, logic [ELEM_WIDTH-1:0] lo);
        return minor_t'(e) * minor_t'($signed({1'b0, lo}));
    endfunction

    function automatic minor_t mul_high(elem_t e, logic signed [ELEM_WIDTH:0] hi);
        return minor_t'(e) * minor_t'(hi);
    endfunction

    function automatic elem_t sat_quotient(logic [QUO_WIDTH-1:0] q, logic neg);
        logic [ELEM_WIDTH-1:0] mag;
        logic [ELEM_WIDTH-1:0] half;
        mag  = q[ELEM_WIDTH-1:0];
        half = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
        if (neg) begin
            if (q[ELEM_WIDTH] || (mag > half)) begin
                return ELEM_MIN;
            end
            return elem_t'(~mag + 1'b1);
        end
        if (q[ELEM_WIDTH] || mag[ELEM_WIDTH-1]) begin
            return ELEM_MAX;
        end
        return elem_t'(mag);
    endfunction

endpackage

[src/small_matrix_inverse.sv]
// Determinant and inverse of a 1x1, 2x2 or 3x3 matrix of signed Q16.16 elements.
// Input channel: item_valid / item_ready carry one item_t per transaction
// (matrix_size and m11..m33; elements outside the order are ignored).
// Output channel: result_valid / result_ready carry one result_t per input
// transaction, in order: status, determinant and inv11..inv33, each truncated
// toward zero and saturated. A zero determinant or matrix_size 0 gives status
// singular with all numeric fields zero.
// Throughput: one matrix per cycle unless the receiver stalls. Six stages form the
// products, cofactors and determinant, then a restoring divider with one quotient bit
// per stage (33 stages, nine lanes) forms the inverse, and a last stage saturates.
// Each stage advances while it or any later stage holds a bubble or the receiver
// takes the result, so a stalled receiver blocks the input only once every
// stage is full; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears every stage valid; data is not reset.
module small_matrix_inverse
    import smi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    `include "small_matrix_inverse_assert.svh"

    localparam int ST_F   = 5;
    localparam int ST_DIV = 6;
    localparam int ST_OUT = STAGES - 1;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] adv;

    for (genvar g = 0; g < STAGES; g++) begin : g_adv
        assign adv[g] = result_ready | ~(&valid_reg[STAGES-1:g]);
    end

    assign item_ready = adv[0];

    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            if (adv[k])
            begin
                valid_next[k] = (k == 0) ? item_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end
            else
            begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    elem_t elem_in [NUM_ELEMS];
    assign elem_in[0] = item.m11;
    assign elem_in[1] = item.m12;
    assign elem_in[2] = item.m13;
    assign elem_in[3] = item.m21;
    assign elem_in[4] = item.m22;
    assign elem_in[5] = item.m23;
    assign elem_in[6] = item.m31;
    assign elem_in[7] = item.m32;
    assign elem_in[8] = item.m33;

    // Stage A: products for the nine cofactors
    elem_t      a_elem_reg   [NUM_ELEMS];
    prod_t      a_prod_p_reg [NUM_ELEMS];
    prod_t      a_prod_s_reg [NUM_ELEMS];
    logic [1:0] a_size_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            a_size_reg <= item.matrix_size;
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                a_elem_reg[k]   <= elem_in[k];
                a_prod_p_reg[k] <= mul_elems(elem_in[MINOR_P[k]], elem_in[MINOR_Q[k]]);
                a_prod_s_reg[k] <= mul_elems(elem_in[MINOR_S[k]], elem_in[MINOR_T[k]]);
            end
        end
    end

    // Stage B: cofactors
    elem_t      b_elem_reg  [NUM_ELEMS];
    minor_t     b_minor_reg [NUM_ELEMS];
    logic [1:0] b_size_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            b_size_reg <= a_size_reg;
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                b_elem_reg[k]  <= a_elem_reg[k];
                b_minor_reg[k] <= minor_t'(a_prod_p_reg[k]) - minor_t'(a_prod_s_reg[k]);
            end
        end
    end

    // Stage C: first-row expansion, cofactor split into low and high halves
    elem_t      c_elem_reg  [NUM_ELEMS];
    minor_t     c_minor_reg [NUM_ELEMS];
    minor_t     c_pl_reg    [3];
    minor_t     c_ph_reg    [3];
    logic [1:0] c_size_reg;

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            c_size_reg <= b_size_reg;
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                c_elem_reg[k]  <= b_elem_reg[k];
                c_minor_reg[k] <= b_minor_reg[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                c_pl_reg[k] <= mul_low(b_elem_reg[k], b_minor_reg[3*k][ELEM_WIDTH-1:0]);
                c_ph_reg[k] <= mul_high(b_elem_reg[k],
                                        $signed(b_minor_reg[3*k][MINOR_WIDTH-1:ELEM_WIDTH]));
            end
        end
    end

    // Stage D: recombine partial products, pick numerators by order
    det_t       d_term_reg [3];
    det_t       d_dalt_reg;
    minor_t     d_num_reg  [NUM_ELEMS];
    logic [1:0] d_size_reg;
    minor_t     num_next   [NUM_ELEMS];

    always_comb
    begin
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            num_next[k] = '0;
        end
        case (c_size_reg)
            SIZE_1:
            begin
                num_next[0] = minor_t'(1);
            end
            SIZE_2:
            begin
                num_next[0] = minor_t'(c_elem_reg[4]);
                num_next[1] = -minor_t'(c_elem_reg[1]);
                num_next[3] = -minor_t'(c_elem_reg[3]);
                num_next[4] = minor_t'(c_elem_reg[0]);
            end
            SIZE_3:
            begin
                for (int k = 0; k < NUM_ELEMS; k++)
                begin
                    num_next[k] = c_minor_reg[k];
                end
            end
            default:
            begin
                num_next[0] = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            d_size_reg <= c_size_reg;
            d_dalt_reg <= (c_size_reg == SIZE_1) ? det_t'(c_elem_reg[0]) : det_t'(c_minor_reg[8]);
            for (int k = 0; k < 3; k++)
            begin
                d_term_reg[k] <= (det_t'(c_ph_reg[k]) <<< ELEM_WIDTH) + det_t'(c_pl_reg[k]);
            end
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                d_num_reg[k] <= num_next[k];
            end
        end
    end

    // Stage E: determinant
    det_t       e_det_reg;
    minor_t     e_num_reg [NUM_ELEMS];
    logic [1:0] e_size_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            e_size_reg <= d_size_reg;
            e_det_reg  <= (d_size_reg == SIZE_3) ?
                          (d_term_reg[0] + d_term_reg[1] + d_term_reg[2]) : d_dalt_reg;
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                e_num_reg[k] <= d_num_reg[k];
            end
        end
    end

    // Stage F: magnitudes, signs, scaled determinant
    logic                   det_neg;
    logic [DET_WIDTH-1:0]   det_mag;
    det_t                   det_shift;
    elem_t                  det_sat;
    logic [MINOR_WIDTH-1:0] num_mag [NUM_ELEMS];

    always_comb
    begin
        det_neg = e_det_reg[DET_WIDTH-1];
        det_mag = det_neg ? DET_WIDTH'(-e_det_reg) : DET_WIDTH'(e_det_reg);
        case (e_size_reg)
            SIZE_2:
            begin
                det_shift = (e_det_reg + (det_neg ? det_t'((64'd1 << FRAC_BITS) - 64'd1)
                                                  : det_t'(0))) >>> FRAC_BITS;
            end
            SIZE_3:
            begin
                det_shift = (e_det_reg + (det_neg ? det_t'((64'd1 << (2*FRAC_BITS)) - 64'd1)
                                                  : det_t'(0))) >>> (2*FRAC_BITS);
            end
            default:
            begin
                det_shift = e_det_reg;
            end
        endcase
        if (det_shift > det_t'(ELEM_MAX))
        begin
            det_sat = ELEM_MAX;
        end
        else if (det_shift < det_t'(ELEM_MIN))
        begin
            det_sat = ELEM_MIN;
        end
        else
        begin
            det_sat = det_shift[ELEM_WIDTH-1:0];
        end
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            num_mag[k] = e_num_reg[k][MINOR_WIDTH-1] ? MINOR_WIDTH'(-e_num_reg[k])
                                                     : MINOR_WIDTH'(e_num_reg[k]);
        end
    end

    logic [REM_WIDTH-1:0] f_rem_reg [NUM_ELEMS];
    logic [DET_WIDTH-1:0] f_dm_reg;
    logic [NUM_ELEMS-1:0] f_neg_reg;
    logic                 f_sing_reg;
    elem_t                f_det_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_F])
        begin
            f_dm_reg   <= det_mag;
            f_sing_reg <= (e_size_reg == SIZE_NONE) || (e_det_reg == '0);
            f_det_reg  <= det_sat;
            for (int k = 0; k < NUM_ELEMS; k++)
            begin
                f_rem_reg[k] <= REM_WIDTH'(num_mag[k]) << (2*FRAC_BITS);
                f_neg_reg[k] <= e_num_reg[k][MINOR_WIDTH-1] ^ det_neg;
            end
        end
    end

    // Restoring divider: one quotient bit per stage, most significant first
    logic [REM_WIDTH-1:0] dv_rem_reg  [ELEM_WIDTH+1][NUM_ELEMS];
    logic [QUO_WIDTH-1:0] dv_q_reg    [ELEM_WIDTH+1][NUM_ELEMS];
    logic [DET_WIDTH-1:0] dv_dm_reg   [ELEM_WIDTH+1];
    logic [NUM_ELEMS-1:0] dv_neg_reg  [ELEM_WIDTH+1];
    logic                 dv_sing_reg [ELEM_WIDTH+1];
    elem_t                dv_det_reg  [ELEM_WIDTH+1];

    for (genvar j = 0; j <= ELEM_WIDTH; j++) begin : g_div
        logic [REM_WIDTH-1:0] rem_in   [NUM_ELEMS];
        logic [QUO_WIDTH-1:0] q_in     [NUM_ELEMS];
        logic [REM_WIDTH-1:0] rem_next [NUM_ELEMS];
        logic [QUO_WIDTH-1:0] q_next   [NUM_ELEMS];
        logic [DET_WIDTH-1:0] dm_in;
        logic [NUM_ELEMS-1:0] neg_in;
        logic                 sing_in;
        elem_t                det_in;

        if (j == 0) begin : g_first
            assign rem_in  = f_rem_reg;
            assign q_in    = '{default: '0};
            assign dm_in   = f_dm_reg;
            assign neg_in  = f_neg_reg;
            assign sing_in = f_sing_reg;
            assign det_in  = f_det_reg;
        end
        else begin : g_rest
            assign rem_in  = dv_rem_reg[j-1];
            assign q_in    = dv_q_reg[j-1];
            assign dm_in   = dv_dm_reg[j-1];
            assign neg_in  = dv_neg_reg[j-1];
            assign sing_in = dv_sing_reg[j-1];
            assign det_in  = dv_det_reg[j-1];
        end

        for (genvar l = 0; l < NUM_ELEMS; l++) begin : g_lane
            logic [REM_WIDTH:0] trial;
            assign trial = {1'b0, rem_in[l]}
                         - {1'b0, REM_WIDTH'(dm_in) << (ELEM_WIDTH - j)};
            assign rem_next[l] = trial[REM_WIDTH] ? rem_in[l] : trial[REM_WIDTH-1:0];
            assign q_next[l]   = q_in[l] | ({QUO_WIDTH{~trial[REM_WIDTH]}}
                                           & (QUO_WIDTH'(1) << (ELEM_WIDTH - j)));
        end

        always_ff @(posedge clk)
        begin
            if (adv[ST_DIV+j])
            begin
                dv_rem_reg[j]  <= rem_next;
                dv_q_reg[j]    <= q_next;
                dv_dm_reg[j]   <= dm_in;
                dv_neg_reg[j]  <= neg_in;
                dv_sing_reg[j] <= sing_in;
                dv_det_reg[j]  <= det_in;
            end
        end
    end

    // Output stage: sign, saturate, clear on singular
    result_t result_reg;
    result_t result_next;
    elem_t   inv [NUM_ELEMS];

    always_comb
    begin
        for (int k = 0; k < NUM_ELEMS; k++)
        begin
            inv[k] = dv_sing_reg[ELEM_WIDTH] ? elem_t'(0)
                   : sat_quotient(dv_q_reg[ELEM_WIDTH][k], dv_neg_reg[ELEM_WIDTH][k]);
        end
        result_next.status      = dv_sing_reg[ELEM_WIDTH] ? STATUS_SINGULAR : STATUS_OK;
        result_next.determinant = dv_sing_reg[ELEM_WIDTH] ? elem_t'(0) : dv_det_reg[ELEM_WIDTH];
        result_next.inv11       = inv[0];
        result_next.inv12       = inv[1];
        result_next.inv13       = inv[2];
        result_next.inv21       = inv[3];
        result_next.inv22       = inv[4];
        result_next.inv23       = inv[5];
        result_next.inv31       = inv[6];
        result_next.inv32       = inv[7];
        result_next.inv33       = inv[8];
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg[ST_OUT];

    `SMI_ASSERT_SAME(a_bubble_opens_input, !(&valid_reg), item_ready, "input blocked with a bubble in flight")
    `SMI_ASSERT_SAME(a_stall_from_output, !item_ready, result_valid && !result_ready, "input blocked without an output stall")
    `SMI_ASSERT_SAME(a_zero_det_singular, valid_reg[ST_F] && (f_dm_reg == '0), f_sing_reg, "zero determinant not flagged singular")
    `SMI_ASSERT_SAME(a_singular_zero, result_valid && (result.status == STATUS_SINGULAR), (result.determinant == '0) && (result.inv11 == '0) && (result.inv22 == '0) && (result.inv33 == '0), "singular result carries nonzero fields")

endmodule
